@@ src/trd_pkg.sv @@
`timescale 1ns / 1ps

package trd_pkg;

	// Fixed widths of the pixel data path and of the configuration port.
	localparam int PIXEL_W        = 32;
	localparam int COUNT_W        = 8;
	localparam int TOTAL_W        = 32;
	localparam int BPP_W          = 3;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 4;
	localparam int REG_IDX_W      = 2;

	// Default for the largest pixel the decoder assembles, in bytes.
	localparam int MAX_PIXEL_BYTES_DEF = 4;

	// Smallest pixel size the decoder uses.
	localparam logic [BPP_W-1:0] MIN_PIXEL_BYTES = 3'd2;

	// Packet header fields.
	localparam int          RUN_FLAG_BIT = 7;
	localparam logic [7:0]  COUNT_MASK   = 8'h7F;

	// Depth of the queue between the decoder and the output side.
	localparam int QUEUE_DEPTH = 2;

	// Register indexes on the configuration port.
	localparam logic [REG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PIXEL_TOTAL     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RUN_LENGTH_MODE = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;
	localparam logic               MODE_RESET  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERRUN   = 2'd1,
		ST_EARLY_END = 2'd2
	} status_t;

	typedef struct packed {
		logic [BPP_W-1:0]   bytes_per_pixel;
		logic [TOTAL_W-1:0] pixel_total;
		logic               run_length_mode;
	} cfg_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_value;
		logic [COUNT_W-1:0] repeat_count;
		logic               image_done;
		status_t            status;
	} result_t;

endpackage

@@ src/trd_byte_if.sv @@
`timescale 1ns / 1ps

interface trd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output first_byte, output end_of_input,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input end_of_input,
		output ready);
endinterface

@@ src/trd_pixel_if.sv @@
`timescale 1ns / 1ps

interface trd_pixel_if;
	import trd_pkg::*;

	logic                valid;
	logic                ready;
	logic [PIXEL_W-1:0]  pixel_value;
	logic [COUNT_W-1:0]  repeat_count;
	logic                image_done;
	status_t             status;

	modport source (output valid, output pixel_value, output repeat_count, output image_done,
		output status, input ready);
	modport sink (input valid, input pixel_value, input repeat_count, input image_done,
		input status, output ready);
endinterface

@@ src/trd_regs.sv @@
`timescale 1ns / 1ps

module trd_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [trd_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [trd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [trd_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output trd_pkg::cfg_t                    cfg
);
	import trd_pkg::*;

	logic [BPP_W-1:0]     bpp_q;
	logic [TOTAL_W-1:0]   total_q;
	logic                 mode_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q   <= BPP_RESET;
			total_q <= TOTAL_RESET;
			mode_q  <= MODE_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_BYTES_PER_PIXEL: bpp_q   <= pwdata[BPP_W-1:0];
				REG_PIXEL_TOTAL:     total_q <= pwdata[TOTAL_W-1:0];
				REG_RUN_LENGTH_MODE: mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BYTES_PER_PIXEL: prdata = APB_DATA_W'(bpp_q);
			REG_PIXEL_TOTAL:     prdata = APB_DATA_W'(total_q);
			REG_RUN_LENGTH_MODE: prdata = APB_DATA_W'(mode_q);
			default:             prdata = '0;
		endcase
	end

	assign cfg.bytes_per_pixel = bpp_q;
	assign cfg.pixel_total     = total_q;
	assign cfg.run_length_mode = mode_q;
endmodule

@@ src/trd_front.sv @@
`timescale 1ns / 1ps

module trd_front #(
	parameter int MAX_PIXEL_BYTES = trd_pkg::MAX_PIXEL_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  trd_pkg::cfg_t    cfg,
	trd_byte_if.sink         byte_chan,
	input  logic             room,
	output logic             push,
	output trd_pkg::result_t push_data
);
	import trd_pkg::*;

	localparam int AW  = MAX_PIXEL_BYTES * 8;
	localparam int BIW = $clog2(MAX_PIXEL_BYTES);

	logic                 active_q, expect_header_q, packet_is_run_q;
	logic [COUNT_W-1:0]   packet_left_q;
	logic [BIW-1:0]       byte_idx_q;
	logic [AW-1:0]        assembly_q;
	logic [TOTAL_W-1:0]   image_left_q;

	logic                 act_n, eh_n, pir_n;
	logic [COUNT_W-1:0]   ppl_n;
	logic [BIW-1:0]       bip_n;
	logic [AW-1:0]        asm_n;
	logic [TOTAL_W-1:0]   ipl_n;
	logic                 emit, go_idle, accept;
	logic [COUNT_W-1:0]   count, rep;
	logic [BPP_W-1:0]     pb;
	logic [7:0]           b;
	result_t              res;

	assign accept         = byte_chan.valid & room;
	assign byte_chan.ready = room;
	assign b              = byte_chan.data_byte;

	// Out-of-range pixel sizes are pulled into the supported range.
	always_comb begin
		if (cfg.bytes_per_pixel < MIN_PIXEL_BYTES)
			pb = MIN_PIXEL_BYTES;
		else if (cfg.bytes_per_pixel > BPP_W'(MAX_PIXEL_BYTES))
			pb = BPP_W'(MAX_PIXEL_BYTES);
		else
			pb = cfg.bytes_per_pixel;
	end

	always_comb begin
		act_n   = active_q;
		eh_n    = expect_header_q;
		pir_n   = packet_is_run_q;
		ppl_n   = packet_left_q;
		bip_n   = byte_idx_q;
		asm_n   = assembly_q;
		ipl_n   = image_left_q;
		emit    = 1'b0;
		go_idle = 1'b0;
		count   = ({1'b0, b[6:0]} & COUNT_MASK) + 8'd1;
		rep     = 8'd1;
		res     = '0;

		// A first byte drops any image in flight and loads the pixel budget.
		if (byte_chan.first_byte) begin
			act_n = (cfg.pixel_total != '0);
			eh_n  = 1'b1;
			pir_n = 1'b0;
			ppl_n = '0;
			bip_n = '0;
			asm_n = '0;
			ipl_n = cfg.pixel_total;
		end

		if (act_n) begin
			if (cfg.run_length_mode && eh_n) begin
				// Packet header.
				if (TOTAL_W'(count) > ipl_n) begin
					go_idle          = 1'b1;
					emit             = 1'b1;
					res.repeat_count = count;
					res.status       = ST_OVERRUN;
				end else begin
					pir_n = b[RUN_FLAG_BIT];
					ppl_n = count;
					eh_n  = 1'b0;
					bip_n = '0;
					asm_n = '0;
					if (byte_chan.end_of_input) begin
						go_idle    = 1'b1;
						emit       = 1'b1;
						res.status = ST_EARLY_END;
					end
				end
			end else begin
				asm_n = asm_n | (AW'(b) << {bip_n, 3'b000});
				if (BPP_W'(bip_n) + 3'd1 < pb) begin
					bip_n = bip_n + 1'b1;
					if (byte_chan.end_of_input) begin
						go_idle    = 1'b1;
						emit       = 1'b1;
						res.status = ST_EARLY_END;
					end
				end else begin
					// The pixel is complete.
					if (!cfg.run_length_mode) begin
						rep = 8'd1;
					end else if (pir_n) begin
						rep   = ppl_n;
						ppl_n = '0;
					end else begin
						rep   = 8'd1;
						ppl_n = ppl_n - 8'd1;
					end
					if (rep == '0)
						rep = 8'd1;
					if (TOTAL_W'(rep) > ipl_n)
						rep = ipl_n[COUNT_W-1:0];
					ipl_n            = ipl_n - TOTAL_W'(rep);
					emit             = 1'b1;
					res.pixel_value  = PIXEL_W'(asm_n);
					res.repeat_count = rep;
					res.image_done   = (ipl_n == '0);
					res.status       = ST_OK;
					bip_n            = '0;
					asm_n            = '0;
					if (ppl_n == '0)
						eh_n = 1'b1;
					if (res.image_done) begin
						go_idle = 1'b1;
					end else if (byte_chan.end_of_input) begin
						res.status = ST_EARLY_END;
						go_idle    = 1'b1;
					end
				end
			end
		end

		if (go_idle) begin
			act_n = 1'b0;
			eh_n  = 1'b1;
			pir_n = 1'b0;
			ppl_n = '0;
			bip_n = '0;
			asm_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q        <= 1'b0;
			expect_header_q <= 1'b1;
			packet_is_run_q <= 1'b0;
			packet_left_q   <= '0;
			byte_idx_q      <= '0;
			assembly_q      <= '0;
			image_left_q    <= '0;
		end else if (accept) begin
			active_q        <= act_n;
			expect_header_q <= eh_n;
			packet_is_run_q <= pir_n;
			packet_left_q   <= ppl_n;
			byte_idx_q      <= bip_n;
			assembly_q      <= asm_n;
			image_left_q    <= ipl_n;
		end
	end

	assign push      = accept & emit;
	assign push_data = res;
endmodule

@@ src/trd_queue.sv @@
`timescale 1ns / 1ps

module trd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  trd_pkg::result_t push_data,
	output logic             room,
	trd_pixel_if.source      pixel_chan
);
	import trd_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	result_t         entry_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   fill_q;
	logic            pop;
	result_t         head;

	assign room = (fill_q != CW'(QUEUE_DEPTH));
	assign pop  = pixel_chan.valid & pixel_chan.ready;
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign pixel_chan.valid        = (fill_q != '0);
	assign pixel_chan.pixel_value  = head.pixel_value;
	assign pixel_chan.repeat_count = head.repeat_count;
	assign pixel_chan.image_done   = head.image_done;
	assign pixel_chan.status       = head.status;
endmodule

@@ src/tga_rle_pixel_decoder.sv @@
`timescale 1ns / 1ps

// TGA pixel-data decoder for raw (type 2) and run-length (type 10) images.
// Bytes of the pixel-data section enter on byte_chan, one item per cycle when
// ready is high; first_byte starts a new image and end_of_input marks the
// last byte the source has. Each finished pixel leaves on pixel_chan as one
// item with its value, a repeat count of 1 to 128, an image_done flag and a
// status that reports a packet overrunning the image or input ending early.
// Configuration (pixel size, pixel total, raw or run-length mode) is written
// over the APB port at byte addresses 0, 4 and 8; the user must do so only
// while the block is idle; the block itself does not enforce this. Bytes are
// taken one per cycle while the queue has room, and the decoder updates all
// of its state in the cycle a byte is accepted. Each result is registered
// into a two-entry queue between the decoder and the output; when the receiver
// stalls, it absorbs up to two results; when full, byte_chan.ready drops
// until an item leaves. Reset clears the decoder to idle, empties the queue
// and restores four bytes per pixel, a total of one pixel and run-length mode.
module tga_rle_pixel_decoder #(
	parameter int MAX_PIXEL_BYTES = trd_pkg::MAX_PIXEL_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	trd_byte_if.sink                       byte_chan,
	trd_pixel_if.source                    pixel_chan,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [trd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [trd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [trd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import trd_pkg::*;

	cfg_t    cfg;
	logic    room;
	logic    push;
	result_t push_data;

	// Configuration registers, read live by the decoder.
	trd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Front: packet and pixel parsing, one byte per cycle while there is room.
	trd_front #(
		.MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.byte_chan (byte_chan),
		.room      (room),
		.push      (push),
		.push_data (push_data)
	);

	// Back: result queue that drives the output channel.
	trd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.room       (room),
		.pixel_chan (pixel_chan)
	);
endmodule
